@@ hdl/labelled_field_extractor_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef LABELLED_FIELD_EXTRACTOR_UNIT_ASSERT_SVH
`define LABELLED_FIELD_EXTRACTOR_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define LFEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LFEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/lfe_pkg.sv @@
// shared types and constants of the labelled field extractor
package lfe_pkg;

  // default sizes
  localparam int FIELD_DEPTH_DEF = 63;
  localparam int LABEL_MAX_DEF   = 8;

  // width of a field length as carried between front and back
  localparam int CNT_MAX_W = 7;

  // terminator of a field
  localparam logic [7:0] CR_BYTE = 8'h0D;

  // configuration register indexes
  localparam logic [1:0] REG_LABEL_BYTES  = 2'd0;
  localparam logic [1:0] REG_LABEL_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_FIELD    = 2'd2;

  // reset value of the buffer size register
  localparam logic [6:0] MAX_FIELD_RESET = 7'd64;

  // result kind, carried on tuser
  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_ABSENT = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  // one finished text waiting for the back end
  typedef struct packed {
    logic                 bank;
    logic [CNT_MAX_W-1:0] count;
    status_t              status;
  } desc_t;

endpackage

@@ hdl/lfe_ram.sv @@
// generic single write port RAM with registered read
module lfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/lfe_front.sv @@
// front end: label search, field capture and per-text verdict
module lfe_front #(
  parameter int FIELD_DEPTH = lfe_pkg::FIELD_DEPTH_DEF,
  parameter int LABEL_MAX   = lfe_pkg::LABEL_MAX_DEF,
  localparam int IDX_W = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic [63:0]         label_bytes,
  input  logic [3:0]          label_length,
  input  logic [6:0]          max_field_size,
  output logic                ram_we,
  output logic [IDX_W:0]      ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                q_push,
  output lfe_pkg::desc_t      q_desc,
  input  logic                q_full
);
  import lfe_pkg::*;

  localparam int WIN_W  = 8 * LABEL_MAX;
  localparam int FILL_W = $clog2(LABEL_MAX + 1);
  localparam int CNT_W  = $clog2(FIELD_DEPTH + 2);

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_CAPTURE = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  phase_t             phase, phase_next;
  logic [WIN_W-1:0]   window, window_next, win_shift, tail, mask;
  logic [FILL_W-1:0]  fill, fill_next, fill_inc;
  logic [CNT_W-1:0]   count, count_next;
  logic               bank;
  logic               accept;
  logic               len_ok;
  logic               hit;
  logic [3:0]         shift_bytes;
  status_t            verdict;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // window after this byte and label compare on its newest bytes
  always_comb begin
    win_shift   = {s_tdata, window[WIN_W-1:8]};
    fill_inc    = (fill < FILL_W'(LABEL_MAX)) ? fill + 1'b1 : fill;
    len_ok      = (label_length != 4'd0) && (label_length <= 4'(LABEL_MAX));
    shift_bytes = 4'(LABEL_MAX) - label_length;
    tail        = win_shift >> {shift_bytes, 3'b000};
    for (int j = 0; j < LABEL_MAX; j++) begin
      mask[8*j +: 8] = (label_length > 4'(j)) ? 8'hFF : 8'h00;
    end
    hit = len_ok && (4'(fill_inc) >= label_length)
          && ((tail & mask) == (label_bytes[WIN_W-1:0] & mask));
  end

  // search and capture step
  always_comb begin
    phase_next  = phase;
    window_next = window;
    fill_next   = fill;
    count_next  = count;
    ram_we      = 1'b0;
    unique case (phase)
      PH_SEARCH: begin
        window_next = win_shift;
        fill_next   = fill_inc;
        if (hit) begin
          phase_next = PH_CAPTURE;
          count_next = '0;
        end
      end
      PH_CAPTURE: begin
        if (s_tdata == CR_BYTE) begin
          phase_next = PH_DONE;
        end else if (count < CNT_W'(FIELD_DEPTH)) begin
          ram_we     = accept;
          count_next = count + 1'b1;
        end else begin
          count_next = CNT_W'(FIELD_DEPTH + 1);
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_SEARCH;
      end
    endcase
  end

  assign ram_waddr = {bank, count[IDX_W-1:0]};
  assign ram_wdata = s_tdata;

  // verdict for a text that ends on this byte
  always_comb begin
    if (phase_next == PH_SEARCH) begin
      verdict = ST_ABSENT;
    end else if (phase_next == PH_CAPTURE || count_next == '0) begin
      verdict = ST_EMPTY;
    end else if (7'(count_next) >= max_field_size
                 || count_next > CNT_W'(FIELD_DEPTH)) begin
      verdict = ST_LONG;
    end else begin
      verdict = ST_FOUND;
    end
  end

  assign q_push        = accept && s_tlast;
  assign q_desc.bank   = bank;
  assign q_desc.count  = CNT_MAX_W'(count_next);
  assign q_desc.status = verdict;

  // per-text state, cleared at the end of each text, when the bank also flips
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SEARCH;
      window <= '0;
      fill   <= '0;
      count  <= '0;
      bank   <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        phase  <= PH_SEARCH;
        window <= '0;
        fill   <= '0;
        count  <= '0;
        bank   <= !bank;
      end else begin
        phase  <= phase_next;
        window <= window_next;
        fill   <= fill_next;
        count  <= count_next;
      end
    end
  end

endmodule

@@ hdl/lfe_queue.sv @@
// two-entry queue of finished texts between front and back
module lfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lfe_pkg::desc_t push_desc,
  input  logic           pop,
  output lfe_pkg::desc_t head,
  output logic           valid,
  output logic           full
);
  import lfe_pkg::*;

  desc_t       slot [2];
  logic        wp, rp;
  logic [1:0]  used;

  assign head  = slot[rp];
  assign valid = (used != 2'd0);
  assign full  = (used == 2'd2);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      if (push && !pop) begin
        used <= used + 2'd1;
      end else if (pop && !push) begin
        used <= used - 2'd1;
      end
    end
  end

endmodule

@@ hdl/lfe_back.sv @@
// back end: drains a stored field or sends a status word
module lfe_back #(
  parameter int FIELD_DEPTH = lfe_pkg::FIELD_DEPTH_DEF,
  localparam int IDX_W = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lfe_pkg::desc_t q_head,
  output logic           q_pop,
  output logic           ram_re,
  output logic [IDX_W:0] ram_raddr,
  input  logic [7:0]     ram_rdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic [1:0]     m_tuser
);
  import lfe_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_FETCH = 3'b010,
    BK_LOAD  = 3'b100
  } bk_state_t;

  bk_state_t         state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic              out_free;
  logic              load_status, load_byte, is_last;

  assign out_free  = !m_tvalid || m_tready;
  assign is_last   = (CNT_MAX_W'(idx) + CNT_MAX_W'(1)) == q_head.count;
  assign ram_raddr = {q_head.bank, idx};

  // sequencer
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    q_pop       = 1'b0;
    ram_re      = 1'b0;
    load_status = 1'b0;
    load_byte   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_head.status != ST_FOUND) begin
            if (out_free) begin
              load_status = 1'b1;
              q_pop       = 1'b1;
            end
          end else begin
            idx_next   = '0;
            state_next = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        ram_re     = 1'b1;
        state_next = BK_LOAD;
      end
      BK_LOAD: begin
        if (out_free) begin
          load_byte = 1'b1;
          if (is_last) begin
            q_pop      = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = BK_FETCH;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_status || load_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_status) begin
      m_tdata <= 8'h00;
      m_tlast <= 1'b1;
      m_tuser <= q_head.status;
    end else if (load_byte) begin
      m_tdata <= ram_rdata;
      m_tlast <= is_last;
      m_tuser <= ST_FOUND;
    end
  end

endmodule

@@ hdl/labelled_field_extractor_unit.sv @@
// top level of the labelled field extractor
//
//   channel  direction  payload
//   s_*      in         tdata: src_byte[7:0], tlast: end_of_text
//   m_*      out        tdata: field_byte[7:0], tlast: run_last, tuser: status[1:0]
//   cfg_*    in         index 0 label bytes, 1 label length, 2 max field size
//
// Input takes one word per cycle; the front end stalls only while both field
// banks hold texts that the back end has not yet loaded in full for output.
// A found field drains word by word (RAM read, then output load), one word at
// a time through the single read port of the field RAM; a status word skips the read.
// Reset is synchronous and clears all control state; RAM contents are not cleared.
// Output stalls hold the word in the output register while input keeps flowing.
module labelled_field_extractor_unit #(
  parameter int FIELD_DEPTH = lfe_pkg::FIELD_DEPTH_DEF,
  parameter int LABEL_MAX   = lfe_pkg::LABEL_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // src_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // field_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lfe_pkg::*;

  localparam int IDX_W     = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
  localparam int RAM_DEPTH = 2 << IDX_W;

  logic [63:0]    label_bytes;
  logic [3:0]     label_length;
  logic [6:0]     max_field_size;
  logic           ram_we, ram_re;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           q_push, q_pop, q_valid, q_full;
  desc_t          q_desc, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      label_bytes    <= '0;
      label_length   <= '0;
      max_field_size <= MAX_FIELD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LABEL_BYTES:  label_bytes    <= cfg_data;
        REG_LABEL_LENGTH: label_length   <= cfg_data[3:0];
        REG_MAX_FIELD:    max_field_size <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // search and capture
  lfe_front #(
    .FIELD_DEPTH (FIELD_DEPTH),
    .LABEL_MAX   (LABEL_MAX)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .label_bytes    (label_bytes),
    .label_length   (label_length),
    .max_field_size (max_field_size),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .q_push         (q_push),
    .q_desc         (q_desc),
    .q_full         (q_full)
  );

  // two banks of field bytes
  lfe_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // finished texts
  lfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid),
    .full      (q_full)
  );

  // result sender
  lfe_back #(
    .FIELD_DEPTH (FIELD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

@@ hdl/lfe_checker.sv @@
// port-level checks of the labelled field extractor and their binding
`include "labelled_field_extractor_unit_assert.svh"

module lfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);
  import lfe_pkg::*;

  // a stalled word stays offered
  `LFEU_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "output word dropped while stalled")

  // a stalled word keeps its payload
  `LFEU_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output payload changed while stalled")

  // a status word is a single closing zero word
  `LFEU_ASSERT(a_status_word, m_tvalid && m_tuser != ST_FOUND |-> m_tlast && m_tdata == 8'h00, "status word not a closing zero word")

  // no word offered right after reset
  `LFEU_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind labelled_field_extractor_unit lfe_checker u_lfe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
